// File: src/bir_pkg.sv
// Shared types, constants and the axis mapping function for the bilinear resize unit.
// Depends on nothing; every other file refers to it by scoped names.
package bir_pkg;

	localparam int unsigned MAX_DIM    = 256;
	localparam int unsigned PIXEL_BITS = 16;
	localparam int unsigned FRAC_BITS  = 16;
	localparam int unsigned IDX_BITS   = $clog2(MAX_DIM);
	localparam int unsigned ADDR_BITS  = 2 * IDX_BITS;
	localparam int unsigned DEPTH      = MAX_DIM * MAX_DIM;
	localparam int unsigned DIM_BITS   = 9;
	localparam int unsigned SCALE_BITS = 20;
	localparam int unsigned TWICE_BITS = DIM_BITS + SCALE_BITS;
	localparam int unsigned WGT_BITS   = FRAC_BITS + 1;
	localparam int unsigned HSUM_BITS  = PIXEL_BITS + FRAC_BITS;
	localparam int unsigned ACC_BITS   = PIXEL_BITS + 2 * FRAC_BITS;
	localparam int unsigned CFG_IDX_BITS  = 3;
	localparam int unsigned CFG_DATA_BITS = SCALE_BITS;
	localparam int unsigned IN_DATA_BITS  = 2 * IDX_BITS + PIXEL_BITS;

	localparam logic [TWICE_BITS-1:0] FRAC_ONE = TWICE_BITS'(1) << FRAC_BITS;
	localparam logic [WGT_BITS-1:0]   WGT_ONE  = WGT_BITS'(1) << FRAC_BITS;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SRC_ROWS = 3'd0,
		CFG_SRC_COLS = 3'd1,
		CFG_TGT_ROWS = 3'd2,
		CFG_TGT_COLS = 3'd3,
		CFG_ROW_SCALE = 3'd4,
		CFG_COL_SCALE = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic                ok;
		logic [IDX_BITS-1:0] ipart;
		logic [FRAC_BITS-1:0] fpart;
	} axis_map_t;

	typedef struct packed {
		logic                 start;
		logic                 ack;
		logic [FRAC_BITS-1:0] fy;
		logic [FRAC_BITS-1:0] fx;
	} interp_ctrl_t;

	typedef struct packed {
		logic                  rd_en;
		logic                  dy;
		logic                  dx;
		logic                  done;
		logic [PIXEL_BITS-1:0] pixel;
	} interp_stat_t;

	// twice = (2*idx+1)*scale; coordinate = (twice - 1.0) / 2, floor.
	function automatic axis_map_t map_axis(input logic [TWICE_BITS-1:0] twice,
	                                       input logic [DIM_BITS-1:0] size);
		logic [DIM_BITS-1:0]   lim;
		logic [TWICE_BITS-2:0] coord;
		logic [TWICE_BITS-2:0] bound;
		axis_map_t             m;
		lim   = (size > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : size;
		coord = (TWICE_BITS-1)'((twice - FRAC_ONE) >> 1);
		bound = (TWICE_BITS-1)'(lim - DIM_BITS'(1)) << FRAC_BITS;
		m.ok    = (twice >= FRAC_ONE) && (lim >= DIM_BITS'(2)) && (coord < bound);
		m.ipart = coord[FRAC_BITS +: IDX_BITS];
		m.fpart = coord[FRAC_BITS-1:0];
		return m;
	endfunction

endpackage

// File: src/bilinear_image_resize_unit.sv
// Top level of the bilinear resize unit: config registers, request sequencer, output register.
// Depends on bir_pkg, bir_store and bir_interp.
//
//  channel   | direction | tdata / payload                        | tuser
//  s_axis    | in        | row_index, col_index, pixel_in          | action
//  m_axis    | out       | pixel_out                               | out_of_range
//  cfg       | in        | cfg_index selects register, cfg_data    | -
//
// A request on the border or out of range skips the neighbor fetch; an interior request
// is paced by the single read port of the source store, which returns the four
// neighbors one per cycle into a shared multiply-accumulate.
// Reset clears control and restores the register defaults; the store is not cleared.
// A stalled output holds in its register while new words are accepted; a finished
// request waits only if that register is still full.
module bilinear_image_resize_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [bir_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,  // row_index, col_index, pixel_in
	input  logic [0:0]                        s_axis_tuser,  // action
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [bir_pkg::PIXEL_BITS-1:0]    m_axis_tdata,  // pixel_out
	output logic [0:0]                        m_axis_tuser,  // out_of_range
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bir_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [bir_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCALE = 4'b0010,
		ST_MAP   = 4'b0100,
		ST_FETCH = 4'b1000
	} state_t;

	state_t state_q;

	logic [bir_pkg::DIM_BITS-1:0]   src_rows_q, src_cols_q, tgt_rows_q, tgt_cols_q;
	logic [bir_pkg::SCALE_BITS-1:0] row_scale_q, col_scale_q;

	logic [bir_pkg::IDX_BITS-1:0]   row_q, col_q, ry_q, cx_q;
	logic [bir_pkg::FRAC_BITS-1:0]  fy_q, fx_q;
	logic [bir_pkg::TWICE_BITS-1:0] twice_r_q, twice_c_q;
	logic                           oot_q, border_q;

	logic                           m_valid_q;
	logic [bir_pkg::PIXEL_BITS-1:0] m_pixel_q;
	logic                           m_oor_q;

	logic [bir_pkg::IDX_BITS-1:0]   s_row, s_col;
	logic [bir_pkg::PIXEL_BITS-1:0] s_pix;
	logic                           in_acc, out_free, imm, imm_oor, load_out;
	logic [bir_pkg::PIXEL_BITS-1:0] load_pixel;
	logic                           load_oor;
	logic [bir_pkg::DIM_BITS-1:0]   row_w, col_w;
	bir_pkg::axis_map_t             map_r, map_c;
	bir_pkg::interp_ctrl_t          ictrl;
	bir_pkg::interp_stat_t          istat;
	logic [bir_pkg::PIXEL_BITS-1:0] rd_data;
	logic [bir_pkg::ADDR_BITS-1:0]  rd_addr;

	assign s_row = s_axis_tdata[bir_pkg::IDX_BITS-1:0];
	assign s_col = s_axis_tdata[bir_pkg::IDX_BITS +: bir_pkg::IDX_BITS];
	assign s_pix = s_axis_tdata[2*bir_pkg::IDX_BITS +: bir_pkg::PIXEL_BITS];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign out_free      = !m_valid_q || m_axis_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_rows_q  <= bir_pkg::DIM_BITS'(bir_pkg::MAX_DIM);
			src_cols_q  <= bir_pkg::DIM_BITS'(bir_pkg::MAX_DIM);
			tgt_rows_q  <= bir_pkg::DIM_BITS'(bir_pkg::MAX_DIM);
			tgt_cols_q  <= bir_pkg::DIM_BITS'(bir_pkg::MAX_DIM);
			row_scale_q <= bir_pkg::SCALE_BITS'(1) << bir_pkg::FRAC_BITS;
			col_scale_q <= bir_pkg::SCALE_BITS'(1) << bir_pkg::FRAC_BITS;
		end else if (cfg_valid && cfg_ready) begin
			case (bir_pkg::cfg_idx_t'(cfg_index))
				bir_pkg::CFG_SRC_ROWS:  src_rows_q  <= cfg_data[bir_pkg::DIM_BITS-1:0];
				bir_pkg::CFG_SRC_COLS:  src_cols_q  <= cfg_data[bir_pkg::DIM_BITS-1:0];
				bir_pkg::CFG_TGT_ROWS:  tgt_rows_q  <= cfg_data[bir_pkg::DIM_BITS-1:0];
				bir_pkg::CFG_TGT_COLS:  tgt_cols_q  <= cfg_data[bir_pkg::DIM_BITS-1:0];
				bir_pkg::CFG_ROW_SCALE: row_scale_q <= cfg_data;
				bir_pkg::CFG_COL_SCALE: col_scale_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign row_w = {1'b0, row_q};
	assign col_w = {1'b0, col_q};

	assign map_r = bir_pkg::map_axis(twice_r_q, src_rows_q);
	assign map_c = bir_pkg::map_axis(twice_c_q, src_cols_q);

	assign imm     = oot_q || border_q || !map_r.ok || !map_c.ok;
	assign imm_oor = oot_q || (!border_q && (!map_r.ok || !map_c.ok));

	always_comb begin
		load_out   = 1'b0;
		load_pixel = '0;
		load_oor   = 1'b0;
		if (state_q == ST_MAP && imm && out_free) begin
			load_out = 1'b1;
			load_oor = imm_oor;
		end else if (state_q == ST_FETCH && istat.done && out_free) begin
			load_out   = 1'b1;
			load_pixel = istat.pixel;
		end
	end

	assign ictrl.start = (state_q == ST_MAP) && !imm;
	assign ictrl.ack   = (state_q == ST_FETCH) && istat.done && out_free;
	assign ictrl.fy    = fy_q;
	assign ictrl.fx    = fx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && s_axis_tuser[0]) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: state_q <= ST_MAP;
				ST_MAP: begin
					if (!imm) begin
						state_q <= ST_FETCH;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FETCH: begin
					if (ictrl.ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			row_q <= s_row;
			col_q <= s_col;
		end
		if (state_q == ST_SCALE) begin
			twice_r_q <= bir_pkg::TWICE_BITS'({row_q, 1'b1})
			           * bir_pkg::TWICE_BITS'(row_scale_q);
			twice_c_q <= bir_pkg::TWICE_BITS'({col_q, 1'b1})
			           * bir_pkg::TWICE_BITS'(col_scale_q);
			oot_q     <= (row_w >= tgt_rows_q) || (col_w >= tgt_cols_q);
			border_q  <= (row_q == '0) || (col_q == '0)
			          || (row_w == tgt_rows_q - bir_pkg::DIM_BITS'(1))
			          || (col_w == tgt_cols_q - bir_pkg::DIM_BITS'(1));
		end
		if (ictrl.start) begin
			ry_q <= map_r.ipart;
			cx_q <= map_c.ipart;
			fy_q <= map_r.fpart;
			fx_q <= map_c.fpart;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_pixel_q <= load_pixel;
			m_oor_q   <= load_oor;
		end
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = m_pixel_q;
	assign m_axis_tuser[0] = m_oor_q;

	assign rd_addr = {ry_q + bir_pkg::IDX_BITS'(istat.dy), cx_q + bir_pkg::IDX_BITS'(istat.dx)};

	bir_store u_store (
		.clk     (clk),
		.wr_en   (in_acc && !s_axis_tuser[0]),
		.wr_addr ({s_row, s_col}),
		.wr_data (s_pix),
		.rd_en   (istat.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bir_interp u_interp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ictrl),
		.rd_data (rd_data),
		.stat    (istat)
	);

endmodule

// File: src/bir_store.sv
// Source image store: one write port and one read port, registered read data.
// Depends on bir_pkg for sizes.
module bir_store (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [bir_pkg::ADDR_BITS-1:0]  wr_addr,
	input  logic [bir_pkg::PIXEL_BITS-1:0] wr_data,
	input  logic                           rd_en,
	input  logic [bir_pkg::ADDR_BITS-1:0]  rd_addr,
	output logic [bir_pkg::PIXEL_BITS-1:0] rd_data
);

	logic [bir_pkg::PIXEL_BITS-1:0] mem [0:bir_pkg::DEPTH-1];
	logic [bir_pkg::PIXEL_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/bir_interp.sv
// Neighbor fetch sequencer and shared multiply-accumulate for one output pixel.
// Depends on bir_pkg for widths and the control/status structs.
module bir_interp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bir_pkg::interp_ctrl_t          ctrl,
	input  logic [bir_pkg::PIXEL_BITS-1:0] rd_data,
	output bir_pkg::interp_stat_t          stat
);

	localparam logic [3:0] STEP_RD00  = 4'd0;
	localparam logic [3:0] STEP_H0A   = 4'd1;
	localparam logic [3:0] STEP_H0B   = 4'd2;
	localparam logic [3:0] STEP_H0C   = 4'd3;
	localparam logic [3:0] STEP_H1A   = 4'd4;
	localparam logic [3:0] STEP_H1B   = 4'd5;
	localparam logic [3:0] STEP_V1    = 4'd6;
	localparam logic [3:0] STEP_SUM   = 4'd7;
	localparam logic [3:0] STEP_DONE  = 4'd8;

	logic                             run_q;
	logic [3:0]                       st_q;
	logic [bir_pkg::HSUM_BITS-1:0]    prod_q;
	logic [bir_pkg::HSUM_BITS-1:0]    hacc_q;
	logic [bir_pkg::ACC_BITS-1:0]     vprod_q;
	logic [bir_pkg::ACC_BITS-1:0]     acc_q;

	logic [bir_pkg::WGT_BITS-1:0]     fx_w, fy_w, gx_w, gy_w, wgt_h, wgt_v;
	logic [bir_pkg::HSUM_BITS:0]      mult_h;
	logic [bir_pkg::ACC_BITS:0]       mult_v;
	logic [bir_pkg::ACC_BITS-1:0]     rnd;

	assign fx_w = {1'b0, ctrl.fx};
	assign fy_w = {1'b0, ctrl.fy};
	assign gx_w = bir_pkg::WGT_ONE - fx_w;
	assign gy_w = bir_pkg::WGT_ONE - fy_w;

	// even neighbors take the left/top weight, odd ones the right/bottom weight
	assign wgt_h  = st_q[0] ? gx_w : fx_w;
	assign wgt_v  = (st_q == STEP_H1A) ? gy_w : fy_w;
	assign mult_h = (bir_pkg::HSUM_BITS+1)'(rd_data) * (bir_pkg::HSUM_BITS+1)'(wgt_h);
	assign mult_v = (bir_pkg::ACC_BITS+1)'(hacc_q) * (bir_pkg::ACC_BITS+1)'(wgt_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			st_q  <= STEP_RD00;
		end else if (ctrl.start) begin
			run_q <= 1'b1;
			st_q  <= STEP_RD00;
		end else if (run_q) begin
			if (st_q == STEP_DONE) begin
				if (ctrl.ack) begin
					run_q <= 1'b0;
				end
			end else begin
				st_q <= st_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_q) begin
			case (st_q)
				STEP_H0A: begin
					prod_q <= mult_h[bir_pkg::HSUM_BITS-1:0];
				end
				STEP_H0B: begin
					prod_q <= mult_h[bir_pkg::HSUM_BITS-1:0];
					hacc_q <= prod_q;
				end
				STEP_H0C: begin
					prod_q <= mult_h[bir_pkg::HSUM_BITS-1:0];
					hacc_q <= hacc_q + prod_q;
				end
				STEP_H1A: begin
					prod_q  <= mult_h[bir_pkg::HSUM_BITS-1:0];
					hacc_q  <= prod_q;
					vprod_q <= mult_v[bir_pkg::ACC_BITS-1:0];
				end
				STEP_H1B: begin
					hacc_q <= hacc_q + prod_q;
					acc_q  <= vprod_q;
				end
				STEP_V1: begin
					vprod_q <= mult_v[bir_pkg::ACC_BITS-1:0];
				end
				STEP_SUM: begin
					acc_q <= acc_q + vprod_q;
				end
				default: begin
				end
			endcase
		end
	end

	// round half up, drop both fraction scalings
	assign rnd = acc_q + (bir_pkg::ACC_BITS'(1) << (2 * bir_pkg::FRAC_BITS - 1));

	assign stat.rd_en = run_q && (st_q <= STEP_H0C);
	assign stat.dy    = st_q[1];
	assign stat.dx    = st_q[0];
	assign stat.done  = run_q && (st_q == STEP_DONE);
	assign stat.pixel = rnd[bir_pkg::ACC_BITS-1 -: bir_pkg::PIXEL_BITS];

endmodule

// File: src/bir_checker.sv
// Port-level checks for the bilinear resize unit, attached to the top level by bind.
// Depends on bir_pkg for port widths.
module bir_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic [0:0]                        s_axis_tuser,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [bir_pkg::PIXEL_BITS-1:0]    m_axis_tdata,
	input logic [0:0]                        m_axis_tuser
);

	// hold a stalled output word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output word changed while stalled");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("out-of-range result with nonzero pixel");

	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> !s_axis_tready)
		else $error("request did not block the input");

	a_wr_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] |=> s_axis_tready)
		else $error("pixel write blocked the input");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without a request in progress");

endmodule

bind bilinear_image_resize_unit bir_checker u_bir_checker (.*);
